### design/tfe_pkg.sv
// ----------------------------------------------------------------------------
// tfe_pkg
// Shared constants and types of the timed fade engine: command codes,
// fixed-point widths and the divider request and response bundles.
// ----------------------------------------------------------------------------
package tfe_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_W     = 4;
  localparam int LVL_W      = 8;
  localparam int MAX_LEVEL  = 255;
  localparam int FRAC_BITS  = 16;
  localparam int TICKS_W    = 16;
  localparam int POS_W      = LVL_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(POS_W);

  localparam logic [2:0] CMD_SET_LEVEL  = 3'd0;
  localparam logic [2:0] CMD_START_FADE = 3'd1;
  localparam logic [2:0] CMD_STOP_FADE  = 3'd2;
  localparam logic [2:0] CMD_TICK       = 3'd3;
  localparam logic [2:0] CMD_READ_LEVEL = 3'd4;

  typedef struct packed {
    logic               start;
    logic [POS_W-1:0]   dividend;
    logic [TICKS_W-1:0] divisor;
  } tfe_div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quotient;
  } tfe_div_rsp_t;

endpackage

### design/timed_fade_engine_unit.sv
// ----------------------------------------------------------------------------
// timed_fade_engine_unit
// Sixteen fader slots, each with a level and an optional linear fade that a
// tick advances by a fixed-point step.
// ----------------------------------------------------------------------------
// Set, stop and unknown commands are done in the idle state. A start waits in
// the division state for the one-bit-per-cycle divider that works out the
// 24-bit step. A read loads the output register, and a tick walks all sixteen
// slots, updating and reporting one slot per cycle through the output register
// unless stalled. The block takes no new transaction until the current one
// is finished, while a finished result may still wait in the output register.
module timed_fade_engine_unit
  import tfe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [LVL_W-1:0]   level_value_i,
  input  logic [TICKS_W-1:0] fade_ticks_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SLOT_W-1:0]  out_slot_o,
  output logic [LVL_W-1:0]   out_level_o,
  output logic               fading_o,
  output logic               last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_TICK = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic [LVL_W-1:0]   level_q  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] active_q;
  logic [NUM_SLOTS-1:0] up_q;
  logic [LVL_W-1:0]   target_q [NUM_SLOTS];
  logic [POS_W-1:0]   pos_q    [NUM_SLOTS];
  logic [POS_W-1:0]   step_q   [NUM_SLOTS];

  logic               out_valid_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [LVL_W-1:0]   out_level_q;
  logic               out_fading_q;
  logic               out_last_q;

  logic in_accept;
  logic out_free;
  logic out_load;

  tfe_div_req_t div_req;
  tfe_div_rsp_t div_rsp;

  logic [LVL_W-1:0]   in_tgt;
  logic [LVL_W-1:0]   in_cur;
  logic [LVL_W-1:0]   in_dist;
  logic [TICKS_W-1:0] in_ticks;

  logic [POS_W-1:0] adv_tgt;
  logic [POS_W-1:0] adv_pos;
  logic [POS_W-1:0] adv_step;
  logic [POS_W-1:0] adv_diff;
  logic             adv_reach;
  logic [POS_W-1:0] adv_new;
  logic [POS_W:0]   adv_round;
  logic [LVL_W:0]   adv_lvl_wide;
  logic [LVL_W-1:0] adv_lvl;
  logic [LVL_W-1:0] tick_lvl;
  logic             tick_active;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = out_free && (state_q == ST_TICK || state_q == ST_READ);

  tfe_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_tgt   = (32'(level_value_i) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL) : level_value_i;
  assign in_cur   = level_q[slot_i];
  assign in_dist  = (in_cur < in_tgt) ? (in_tgt - in_cur) : (in_cur - in_tgt);
  assign in_ticks = (fade_ticks_i == '0) ? TICKS_W'(1) : fade_ticks_i;

  assign div_req.start    = in_accept && cmd_i == CMD_START_FADE;
  assign div_req.dividend = {in_dist, {FRAC_BITS{1'b0}}} + POS_W'(in_ticks) - POS_W'(1);
  assign div_req.divisor  = in_ticks;

  assign adv_tgt   = {target_q[slot_q], {FRAC_BITS{1'b0}}};
  assign adv_pos   = pos_q[slot_q];
  assign adv_step  = step_q[slot_q];
  assign adv_diff  = up_q[slot_q] ? (adv_tgt - adv_pos) : (adv_pos - adv_tgt);
  assign adv_reach = up_q[slot_q] ? (adv_pos >= adv_tgt) : (adv_pos <= adv_tgt);

  always_comb begin
    if (adv_reach || adv_diff <= adv_step) begin
      adv_new = adv_tgt;
    end else if (up_q[slot_q]) begin
      adv_new = adv_pos + adv_step;
    end else begin
      adv_new = adv_pos - adv_step;
    end
  end

  assign adv_round    = {1'b0, adv_new} + (POS_W + 1)'(1 << (FRAC_BITS - 1));
  assign adv_lvl_wide = adv_round[POS_W:FRAC_BITS];
  assign adv_lvl      = (32'(adv_lvl_wide) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL)
                                                        : adv_lvl_wide[LVL_W-1:0];

  assign tick_lvl    = active_q[slot_q] ? adv_lvl : level_q[slot_q];
  assign tick_active = active_q[slot_q] && (adv_new != adv_tgt);

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          slot_d = slot_i;
          case (cmd_i)
            CMD_START_FADE: state_d = ST_DIV;
            CMD_TICK: begin
              state_d = ST_TICK;
              slot_d  = '0;
            end
            CMD_READ_LEVEL: state_d = ST_READ;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (out_load) begin
          slot_d = slot_q + 1'b1;
          if (slot_q == SLOT_W'(NUM_SLOTS - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      active_q    <= '0;
      up_q        <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        level_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept) begin
        case (cmd_i)
          CMD_SET_LEVEL: begin
            active_q[slot_i] <= 1'b0;
            level_q[slot_i]  <= in_tgt;
          end
          CMD_START_FADE: begin
            active_q[slot_i] <= 1'b0;
            up_q[slot_i]     <= in_cur < in_tgt;
          end
          CMD_STOP_FADE: active_q[slot_i] <= 1'b0;
          default: ;
        endcase
      end
      if (state_q == ST_DIV && div_rsp.done) begin
        active_q[slot_q] <= 1'b1;
      end
      if (state_q == ST_TICK && out_load) begin
        active_q[slot_q] <= tick_active;
        level_q[slot_q]  <= tick_lvl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && cmd_i == CMD_START_FADE) begin
      target_q[slot_i] <= in_tgt;
      pos_q[slot_i]    <= {in_cur, {FRAC_BITS{1'b0}}};
    end
    if (state_q == ST_DIV && div_rsp.done) begin
      step_q[slot_q] <= div_rsp.quotient;
    end
    if (state_q == ST_TICK && out_load && active_q[slot_q]) begin
      pos_q[slot_q] <= adv_new;
    end
    if (out_load) begin
      out_slot_q <= slot_q;
      if (state_q == ST_TICK) begin
        out_level_q  <= tick_lvl;
        out_fading_q <= tick_active;
        out_last_q   <= slot_q == SLOT_W'(NUM_SLOTS - 1);
      end else begin
        out_level_q  <= level_q[slot_q];
        out_fading_q <= active_q[slot_q];
        out_last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_slot_o  = out_slot_q;
  assign out_level_o = out_level_q;
  assign fading_o    = out_fading_q;
  assign last_o      = out_last_q;

`ifndef NO_ASSERTIONS
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider finished outside the division state");

  a_no_result_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DIV) |=> !$rose(out_valid_q))
    else $error("result produced without a tick or read");

  a_tick_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK && out_load && slot_q != SLOT_W'(NUM_SLOTS - 1))
      |=> state_q == ST_TICK && slot_q == $past(slot_q) + 1'b1)
    else $error("tick sequencer skipped a slot");

  a_tick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK && !out_load) |=> $stable(slot_q))
    else $error("tick sequencer advanced while the output was stalled");
`endif

endmodule

### design/tfe_divider.sv
// ----------------------------------------------------------------------------
// tfe_divider
// Restoring radix-2 divider that produces one quotient bit per cycle and
// pulses done when the full quotient is available.
// ----------------------------------------------------------------------------
module tfe_divider
  import tfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tfe_div_req_t req_i,
  output tfe_div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0]     quo_q, quo_d;
  logic [TICKS_W-1:0]   rem_q, rem_d;
  logic [TICKS_W-1:0]   dvs_q, dvs_d;
  logic [TICKS_W:0]     rem_sh;
  logic [TICKS_W:0]     rem_sub;
  logic                 fits;

  assign rem_sh  = {rem_q, quo_q[POS_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[POS_W-2:0], fits};
      rem_d = fits ? rem_sub[TICKS_W-1:0] : rem_sh[TICKS_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(POS_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
